>>> rtl/core/sbp_pkg.sv
// Shared constants and helpers of the sample bit packer.
// Used by sample_bit_packer_unit and its port checker; no dependencies.
package sbp_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned SAMPLE_BITS = 16;
   localparam int unsigned PEND_BITS = 7;
   localparam int unsigned ACC_BITS = 23;
   localparam int unsigned WIDTH_BITS = 5;
   localparam int unsigned SLOTS = 3;

   localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = 5'd12;
   localparam logic [WIDTH_BITS-1:0] WIDTH_MIN = 5'd1;
   localparam logic [WIDTH_BITS-1:0] WIDTH_MAX = 5'd16;

   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [1:0] slot_count_type;

   // A width of zero packs one bit; anything above sixteen packs sixteen.
   function automatic logic [WIDTH_BITS-1:0] effective_width(
      input logic [WIDTH_BITS-1:0] raw
   );
      logic [WIDTH_BITS-1:0] w;
      w = raw;
      if (raw == '0) begin
         w = WIDTH_MIN;
      end else if (raw > WIDTH_MAX) begin
         w = WIDTH_MAX;
      end
      return w;
   endfunction

endpackage

>>> rtl/core/sample_bit_packer_unit.sv
// Sample bit packer: packs variable-width samples MSB first into bytes.
// Depends on sbp_pkg for constants, types and the width saturation helper.
//
// Usage:
//   The req_ channel carries one sample per item with a last flag. The low
//   sample-width bits (set through csr_write_enable/csr_write_data, reset
//   value 12, saturated to 1..16) are appended to a byte stream, earliest
//   bit in the most significant position. The rsp_ channel carries one byte
//   per item; a last sample flushes any partial byte, zero-padded on the
//   right, and flags the final byte with rsp_last_byte.
//   The first byte of a sample is registered and appears the cycle after the
//   sample is accepted. Each sample yields zero to three bytes, held in a
//   three-slot byte buffer that drains one byte per cycle through the output
//   port while rsp_stall is low. A new sample is taken only when the buffer
//   is empty or drains its only byte in this cycle; a sample that is not
//   last yields at most two bytes.
//   Reset empties the buffer and the partial byte and restores the width.
//   While rsp_stall is high the current byte holds and req_stall stays high
//   whenever a byte is buffered; otherwise it is high while two or more are.
module sample_bit_packer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [sbp_pkg::WIDTH_BITS-1:0]       csr_write_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sbp_pkg::SAMPLE_BITS-1:0]      req_sample_value,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sbp_pkg::BYTE_BITS-1:0]        rsp_byte_value,
   output logic                                 rsp_last_byte
);

   logic [sbp_pkg::WIDTH_BITS-1:0] width_ff;
   logic [sbp_pkg::PEND_BITS-1:0]  pend_bits_ff, pend_bits_in;
   logic [2:0]                     pend_count_ff, pend_count_in;
   sbp_pkg::byte_type              slot_ff [sbp_pkg::SLOTS];
   sbp_pkg::byte_type              slot_in [sbp_pkg::SLOTS];
   sbp_pkg::slot_count_type        fill_ff, fill_in;
   logic                           last_ff, last_in;

   logic                              accept;
   logic                              drain;
   logic [sbp_pkg::WIDTH_BITS-1:0]    width;
   logic [sbp_pkg::SAMPLE_BITS-1:0]   sample;
   logic [sbp_pkg::ACC_BITS-1:0]      acc;
   logic [sbp_pkg::WIDTH_BITS-1:0]    total;
   logic [sbp_pkg::WIDTH_BITS-1:0]    shift_hi, shift_lo;
   logic [1:0]                        full_bytes;
   logic [2:0]                        rem;
   logic [sbp_pkg::PEND_BITS-1:0]     rem_mask;
   sbp_pkg::byte_type                 byte_hi, byte_lo, padded;
   logic                              pad_needed;

   function automatic sbp_pkg::slot_count_type slot_count_of(input logic bit_in);
      return {1'b0, bit_in};
   endfunction

   assign drain     = rsp_valid && !rsp_stall;
   assign req_stall = !((fill_ff == 2'd0) || ((fill_ff == 2'd1) && !rsp_stall));
   assign accept    = req_valid && !req_stall;

   assign rsp_valid      = (fill_ff != 2'd0);
   assign rsp_byte_value = slot_ff[0];
   assign rsp_last_byte  = last_ff && (fill_ff == 2'd1);

   // Bit assembly for one sample: append, split off whole bytes, pad a flush.
   always_comb begin
      width      = sbp_pkg::effective_width(width_ff);
      sample     = req_sample_value &
                   sbp_pkg::SAMPLE_BITS'((17'd1 << width) - 17'd1);
      acc        = (sbp_pkg::ACC_BITS'(pend_bits_ff) << width) |
                   sbp_pkg::ACC_BITS'(sample);
      total      = sbp_pkg::WIDTH_BITS'(pend_count_ff) + width;
      full_bytes = total[4:3];
      rem        = total[2:0];
      shift_hi   = total - 5'd8;
      shift_lo   = total - 5'd16;
      byte_hi    = sbp_pkg::BYTE_BITS'(acc >> shift_hi);
      byte_lo    = sbp_pkg::BYTE_BITS'(acc >> shift_lo);
      rem_mask   = sbp_pkg::PEND_BITS'((8'd1 << rem) - 8'd1);
      padded     = sbp_pkg::BYTE_BITS'(acc[7:0] << (4'd8 - {1'b0, rem}));
      pad_needed = req_last_sample && (rem != 3'd0);
   end

   always_comb begin
      pend_bits_in  = pend_bits_ff;
      pend_count_in = pend_count_ff;
      slot_in       = slot_ff;
      fill_in       = fill_ff;
      last_in       = last_ff;
      if (drain) begin
         slot_in[0] = slot_ff[1];
         slot_in[1] = slot_ff[2];
         fill_in    = fill_ff - 2'd1;
      end
      if (accept) begin
         // The buffer is empty here or drains its only byte this cycle.
         slot_in[0] = (full_bytes != 2'd0) ? byte_hi : padded;
         slot_in[1] = (full_bytes == 2'd2) ? byte_lo : padded;
         slot_in[2] = padded;
         fill_in    = full_bytes + slot_count_of(pad_needed);
         last_in    = req_last_sample;
         if (req_last_sample) begin
            pend_bits_in  = '0;
            pend_count_in = '0;
         end else begin
            pend_bits_in  = acc[sbp_pkg::PEND_BITS-1:0] & rem_mask;
            pend_count_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff      <= sbp_pkg::WIDTH_RESET;
         pend_bits_ff  <= '0;
         pend_count_ff <= '0;
         fill_ff       <= '0;
         last_ff       <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            width_ff <= csr_write_data;
         end
         pend_bits_ff  <= pend_bits_in;
         pend_count_ff <= pend_count_in;
         fill_ff       <= fill_in;
         last_ff       <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

>>> rtl/core/sbp_checker.sv
// Port-level checker for sample_bit_packer_unit, attached by bind.
// Depends on sbp_pkg for field widths.
module sbp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            req_last_sample,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [sbp_pkg::BYTE_BITS-1:0]   rsp_byte_value,
   input logic                            rsp_last_byte
);

   // A held byte keeps its value and flag until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_byte_value) &&
                                 $stable(rsp_last_byte))
      else $error("stalled output byte changed");

   // Reset leaves no byte pending.
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("output valid right after reset");

   // With nothing buffered the block must take a new item.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output buffer empty");

   // A last sample always produces at least one byte on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_sample |=> rsp_valid)
      else $error("last sample produced no byte");

endmodule

bind sample_bit_packer_unit sbp_checker u_sbp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_last_sample (req_last_sample),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_byte_value  (rsp_byte_value),
   .rsp_last_byte   (rsp_last_byte)
);

>>> sim/sample_bit_packer_checker.sv
// Port checker for sample_bit_packer_unit: predicts the packed byte stream
// from accepted samples and compares every accepted output byte.
// Depends on sbp_pkg for widths, types and the reset width.
module sample_bit_packer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [sbp_pkg::WIDTH_BITS-1:0] csr_write_data,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [sbp_pkg::SAMPLE_BITS-1:0] req_sample_value,
   input  logic                           req_last_sample,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [sbp_pkg::BYTE_BITS-1:0]  rsp_byte_value,
   input  logic                           rsp_last_byte,
   output int                             error_count,
   output int                             bytes_outstanding
);

   typedef struct packed {
      sbp_pkg::byte_type value;
      logic              last_flag;
   } packed_byte_type;

   packed_byte_type expected_bytes[$];
   logic [sbp_pkg::WIDTH_BITS-1:0] width_setting = sbp_pkg::WIDTH_RESET;
   logic [sbp_pkg::PEND_BITS-1:0] carry_bits = '0;
   logic [2:0] carry_count = '0;
   int mismatches = 0;

   // Appends the bytes that one sample completes, flushing on the last sample.
   task automatic pack_sample(input logic [sbp_pkg::SAMPLE_BITS-1:0] sample,
                              input logic last);
      int unsigned width;
      int unsigned count;
      int produced;
      logic [sbp_pkg::SAMPLE_BITS-1:0] mask;
      logic [sbp_pkg::ACC_BITS-1:0] acc;
      packed_byte_type entry;
      width = width_setting;
      if (width == 0) begin
         width = 1;
      end else if (width > sbp_pkg::SAMPLE_BITS) begin
         width = sbp_pkg::SAMPLE_BITS;
      end
      mask = sbp_pkg::SAMPLE_BITS'((32'd1 << width) - 32'd1);
      acc = (sbp_pkg::ACC_BITS'(carry_bits) << width) |
            sbp_pkg::ACC_BITS'(sample & mask);
      count = carry_count + width;
      produced = 0;
      while (count >= sbp_pkg::BYTE_BITS) begin
         entry.value = sbp_pkg::byte_type'(acc >> (count - sbp_pkg::BYTE_BITS));
         entry.last_flag = 1'b0;
         expected_bytes.push_back(entry);
         produced++;
         count -= sbp_pkg::BYTE_BITS;
      end
      acc = acc & ((sbp_pkg::ACC_BITS'(1) << count) - sbp_pkg::ACC_BITS'(1));
      if (last) begin
         if (count > 0) begin
            entry.value = sbp_pkg::byte_type'(acc << (sbp_pkg::BYTE_BITS - count));
            entry.last_flag = 1'b0;
            expected_bytes.push_back(entry);
            produced++;
         end
         count = 0;
         acc = '0;
         if (produced > 0) begin
            expected_bytes[expected_bytes.size() - 1].last_flag = 1'b1;
         end
      end
      carry_bits = acc[sbp_pkg::PEND_BITS-1:0];
      carry_count = count[2:0];
   endtask

   always @(posedge clock) begin
      packed_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         width_setting = sbp_pkg::WIDTH_RESET;
         carry_bits = '0;
         carry_count = '0;
      end else begin
         // Output bytes always come from items accepted at earlier edges.
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("unexpected byte %02h last %0d at %0t",
                           rsp_byte_value, rsp_last_byte, $time);
               end
            end else begin
               want = expected_bytes.pop_front();
               if (want.value !== rsp_byte_value ||
                   want.last_flag !== rsp_last_byte) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display({"byte mismatch at %0t: expected %02h last %0d,",
                               " got %02h last %0d"},
                              $time, want.value, want.last_flag,
                              rsp_byte_value, rsp_last_byte);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            width_setting = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            pack_sample(req_sample_value, req_last_sample);
         end
      end
      error_count <= mismatches;
      bytes_outstanding <= expected_bytes.size();
   end

endmodule

>>> sim/tb_sample_bit_packer_unit.sv
// Testbench top for sample_bit_packer_unit: drives samples, width writes and
// output back-pressure, and reports the verdict of sample_bit_packer_checker.
// Depends on sbp_pkg, sample_bit_packer_unit and sample_bit_packer_checker.
module tb_sample_bit_packer_unit;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [sbp_pkg::WIDTH_BITS-1:0] csr_write_data;
   logic req_valid;
   logic req_stall;
   logic [sbp_pkg::SAMPLE_BITS-1:0] req_sample_value;
   logic req_last_sample;
   logic rsp_valid;
   logic rsp_stall;
   logic [sbp_pkg::BYTE_BITS-1:0] rsp_byte_value;
   logic rsp_last_byte;

   int error_count;
   int bytes_outstanding;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   bit hold_request = 1'b0;

   sample_bit_packer_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_last_sample  (req_last_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_byte    (rsp_last_byte)
   );

   sample_bit_packer_checker u_check (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample_value  (req_sample_value),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_last_byte     (rsp_last_byte),
      .error_count       (error_count),
      .bytes_outstanding (bytes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // Output back-pressure; a hold request stalls the output for a long stretch.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (80) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   // Offers one sample and returns after the item is taken and any idle gap.
   task automatic offer_sample(input logic [sbp_pkg::SAMPLE_BITS-1:0] value,
                               input logic last);
      req_valid <= 1'b1;
      req_sample_value <= value;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Waits until every expected byte has come out and the block is quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bytes_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_sample_width(input logic [sbp_pkg::WIDTH_BITS-1:0] width);
      csr_write_enable <= 1'b1;
      csr_write_data <= width;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [sbp_pkg::WIDTH_BITS-1:0] pick_width();
      logic [sbp_pkg::WIDTH_BITS-1:0] width;
      case ($urandom_range(0, 3))
         0: width = sbp_pkg::WIDTH_MIN;
         1: width = sbp_pkg::WIDTH_MAX;
         default: width = sbp_pkg::WIDTH_BITS'($urandom_range(0, 31));
      endcase
      return width;
   endfunction

   task automatic run_random_phase(input int sample_total, input int send_pct,
                                   input int recv_pct, input bit long_hold);
      int sent;
      int since_config;
      int buffer_len;
      logic [sbp_pkg::SAMPLE_BITS-1:0] value;
      logic last;
      sent = 0;
      since_config = 0;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      settle_block();
      set_sample_width(pick_width());
      if (long_hold) begin
         hold_request = 1'b1;
      end
      while (sent < sample_total) begin
         buffer_len = $urandom_range(1, 12);
         for (int k = 0; k < buffer_len; k++) begin
            case ($urandom_range(0, 9))
               0: value = '1;
               1: value = '0;
               default: value = sbp_pkg::SAMPLE_BITS'($urandom);
            endcase
            last = (k == buffer_len - 1) || ($urandom_range(0, 19) == 0);
            offer_sample(value, last);
            sent++;
            since_config++;
            // Occasionally change the width with bits still pending.
            if (!last && $urandom_range(0, 49) == 0) begin
               settle_block();
               set_sample_width(pick_width());
               since_config = 0;
            end
         end
         if (since_config >= 20) begin
            settle_block();
            set_sample_width(pick_width());
            since_config = 0;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_sample_value = '0;
      req_last_sample = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 11;
      receiver_idle_pct = 47;

      // Reset width of twelve, with bits above the width set.
      offer_sample(16'hFFFF, 1'b0);
      offer_sample(16'h0000, 1'b0);
      offer_sample(16'h1234, 1'b1);
      settle_block();
      set_sample_width(sbp_pkg::WIDTH_MAX);
      offer_sample(16'hFFFF, 1'b0);
      offer_sample(16'h0000, 1'b0);
      offer_sample(16'hA5C3, 1'b1);
      // A width of zero packs single bits.
      settle_block();
      set_sample_width(5'd0);
      offer_sample(16'h0001, 1'b0);
      offer_sample(16'hFFFE, 1'b0);
      offer_sample(16'h0001, 1'b1);
      // The largest register value saturates to sixteen.
      settle_block();
      set_sample_width(5'd31);
      offer_sample(16'h8001, 1'b1);
      settle_block();
      set_sample_width(5'd8);
      offer_sample(16'h017F, 1'b0);
      offer_sample(16'hFF80, 1'b1);
      // Width change with five bits still pending, then a flush.
      settle_block();
      set_sample_width(5'd7);
      offer_sample(16'h0055, 1'b0);
      offer_sample(16'h002A, 1'b0);
      offer_sample(16'h007F, 1'b0);
      settle_block();
      set_sample_width(5'd17);
      offer_sample(16'hFFFF, 1'b1);
      // A lone one-bit last sample still yields a byte.
      settle_block();
      set_sample_width(sbp_pkg::WIDTH_MIN);
      offer_sample(16'hFFFF, 1'b1);

      run_random_phase(100, 11, 47, 1'b0);
      run_random_phase(100, 47, 11, 1'b0);
      run_random_phase(100, 0, 0, 1'b1);

      settle_block();
      repeat (8) @(posedge clock);
      if (error_count == 0 && bytes_outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/core/sbp_pkg.sv
rtl/core/sample_bit_packer_unit.sv
rtl/core/sbp_checker.sv
sim/sample_bit_packer_checker.sv
sim/tb_sample_bit_packer_unit.sv
